>>> hdl/rled_pkg.sv
// Shared types and constants for the run-length pixel decoder.
`default_nettype none
package rled_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 6;
  localparam int unsigned RunW  = 7;

  // Command type, the top two bits of a byte in command position.
  typedef enum logic [1:0] {
    CMD_BAD_LOW  = 2'b00,
    CMD_ZERO_RUN = 2'b01,
    CMD_HOLD     = 2'b10,
    CMD_PIXEL    = 2'b11
  } cmd_type_t;

  localparam logic [1:0] PixelPrefix = 2'b11;

  typedef struct packed {
    logic [ByteW-1:0] pixel;
    logic [RunW-1:0]  run_length;
    logic             bad_command;
    logic             last_of_input;
  } result_t;

  typedef struct packed {
    logic             held_valid;
    logic [CodeW-1:0] held_code;
    logic             discarding;
  } dec_state_t;

  // Everything one byte produces: up to two results and the next state.
  typedef struct packed {
    result_t    res0;
    result_t    res1;
    logic [1:0] count;
    dec_state_t state_next;
  } dec_out_t;

endpackage
`default_nettype wire

>>> hdl/rled_decode.sv
// Combinational decode of one byte against the held/discard state.
`default_nettype none
module rled_decode (
  input  wire logic [rled_pkg::ByteW-1:0] code_byte,
  input  wire logic                       stream_end,
  input  wire rled_pkg::dec_state_t       state,
  output rled_pkg::dec_out_t              dec
);

  rled_pkg::cmd_type_t cmd;
  rled_pkg::result_t   held_res;
  rled_pkg::result_t   cmd_res;
  logic                cmd_has_res;

  always_comb begin
    cmd = rled_pkg::cmd_type_t'(code_byte[7:6]);

    // Flushed held command: one pixel 11rrrrrr.
    held_res = '{pixel: {rled_pkg::PixelPrefix, state.held_code},
                 run_length: rled_pkg::RunW'(1), bad_command: 1'b0,
                 last_of_input: 1'b0};

    cmd_res     = '{pixel: code_byte, run_length: rled_pkg::RunW'(1),
                    bad_command: 1'b0, last_of_input: 1'b1};
    cmd_has_res = 1'b1;

    dec                       = '0;
    dec.state_next            = state;
    dec.state_next.held_valid = 1'b0;

    unique case (cmd)
      rled_pkg::CMD_ZERO_RUN: begin
        cmd_res.pixel      = '0;
        cmd_res.run_length = {1'b0, code_byte[5:0]} + rled_pkg::RunW'(1);
      end
      rled_pkg::CMD_HOLD: begin
        cmd_res.pixel = {rled_pkg::PixelPrefix, code_byte[5:0]};
        if (!stream_end) begin
          cmd_has_res               = 1'b0;
          dec.state_next.held_valid = 1'b1;
          dec.state_next.held_code  = code_byte[5:0];
        end
      end
      rled_pkg::CMD_BAD_LOW, rled_pkg::CMD_PIXEL: begin
        cmd_res.bad_command       = 1'b1;
        dec.state_next.discarding = !stream_end;
      end
      default: ;
    endcase

    priority if (state.discarding) begin
      dec.state_next            = state;
      dec.state_next.discarding = !stream_end;
      dec.count                 = 2'd0;
    end else if (state.held_valid && cmd == rled_pkg::CMD_PIXEL) begin
      // Held command followed by a pixel byte: one run of that pixel.
      dec.state_next.discarding = 1'b0;
      dec.res0 = '{pixel: code_byte,
                   run_length: {1'b0, state.held_code} + rled_pkg::RunW'(1),
                   bad_command: 1'b0, last_of_input: 1'b1};
      dec.count = 2'd1;
    end else if (state.held_valid) begin
      dec.res0 = held_res;
      dec.res1 = cmd_res;
      if (cmd_has_res) begin
        dec.count = 2'd2;
      end else begin
        dec.res0.last_of_input = 1'b1;
        dec.count              = 2'd1;
      end
    end else begin
      dec.res0  = cmd_res;
      dec.count = cmd_has_res ? 2'd1 : 2'd0;
    end

    if (stream_end) begin
      dec.state_next.held_valid = 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> hdl/rle_pixel_run_decoder_top.sv
// Top level of the run-length pixel decoder with its two-slot result buffer.
//
// Usage
//   Input channel: code_byte/stream_end with in_valid, receiver stall in_stall.
//   stream_end marks the last byte of an encoded stream.
//   Output channel: one (pixel, run_length) run per transfer, with
//   bad_command flagging an invalid command and last_of_input marking the
//   final run produced by a given input byte. Stall is out_stall.
//   A byte is decoded in the cycle of its transfer; its runs appear from the
//   register buffer in the next cycle.
//   Throughput: one byte per cycle while each byte yields at most one run
//   and out_stall stays low. A byte that yields two runs (held command
//   flushed ahead of a new command) stalls the input until the first of
//   its runs has been taken. Bytes that yield no run do not stall the input.
//   in_stall follows out_stall combinationally when one run is waiting.
//   Reset (rst, synchronous) empties the buffer and clears the hold and
//   discard state; the first byte after reset starts a new stream.
//   While out_stall is high the buffered runs hold steady and no further
//   byte is taken once a run is waiting.
`default_nettype none
module rle_pixel_run_decoder_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic [rled_pkg::ByteW-1:0] code_byte,
  input  wire logic                       stream_end,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic [rled_pkg::ByteW-1:0] pixel,
  output      logic [rled_pkg::RunW-1:0]  run_length,
  output      logic                       bad_command,
  output      logic                       last_of_input
);

  rled_pkg::dec_state_t state;
  rled_pkg::dec_out_t   dec;

  // Result buffer: slot0 is presented, slot1 waits behind it.
  rled_pkg::result_t slot0;
  rled_pkg::result_t slot1;
  logic [1:0]        cnt;

  logic in_xfer;
  logic out_xfer;

  rled_decode u_decode (
    .code_byte  (code_byte),
    .stream_end (stream_end),
    .state      (state),
    .dec        (dec)
  );

  // Take a byte only if the buffer will be empty after this cycle's transfer.
  assign in_stall  = (cnt == 2'd2) || ((cnt == 2'd1) && out_stall);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (cnt != 2'd0);
  assign out_xfer  = out_valid && !out_stall;

  assign pixel         = slot0.pixel;
  assign run_length    = slot0.run_length;
  assign bad_command   = slot0.bad_command;
  assign last_of_input = slot0.last_of_input;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      cnt   <= 2'd0;
    end else if (in_xfer) begin
      state <= dec.state_next;
      cnt   <= dec.count;
    end else if (out_xfer) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Payload slots, no reset needed.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      slot0 <= dec.res0;
      slot1 <= dec.res1;
    end else if (out_xfer) begin
      slot0 <= slot1;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result buffer count out of range");

  a_no_hold_while_discard: assert property (@(posedge clk) disable iff (rst)
      !(state.held_valid && state.discarding))
    else $error("hold and discard set together");

  a_two_runs_load: assert property (@(posedge clk) disable iff (rst)
      in_xfer && dec.count == 2'd2 |=> cnt == 2'd2 && out_valid)
    else $error("double result not buffered");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
      in_xfer && stream_end |=> !state.held_valid && !state.discarding)
    else $error("state not cleared at stream end");

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the run-length pixel decoder: directed and random byte streams.
module tb_top;

  // Clock, reset and DUT-facing signals; every input is known from time zero.
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [rled_pkg::ByteW-1:0] code_byte = '0;
  logic                       stream_end = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [rled_pkg::ByteW-1:0] pixel;
  logic [rled_pkg::RunW-1:0]  run_length;
  logic                       bad_command;
  logic                       last_of_input;

  // Idling rates in percent, set per phase.
  int unsigned sender_gap_pct = 0;
  int unsigned sink_stall_pct = 0;

  // Decoder shadow state, updated once per accepted byte.
  logic                       hold_active = 1'b0;
  logic [rled_pkg::CodeW-1:0] hold_code   = '0;
  logic                       dropping    = 1'b0;

  // Runs still owed by the DUT, oldest first.
  rled_pkg::result_t pending_runs[$];

  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  localparam int unsigned QuietLimit = 2000;

  always #5 clk = ~clk;

  rle_pixel_run_decoder_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .code_byte     (code_byte),
    .stream_end    (stream_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel         (pixel),
    .run_length    (run_length),
    .bad_command   (bad_command),
    .last_of_input (last_of_input)
  );

  // ---------------------------------------------------------------------------
  // Run prediction
  // ---------------------------------------------------------------------------

  function automatic rled_pkg::result_t make_run(logic [rled_pkg::ByteW-1:0] pix,
                                                 logic [rled_pkg::RunW-1:0] len,
                                                 logic bad);
    rled_pkg::result_t r;
    r.pixel         = pix;
    r.run_length    = len;
    r.bad_command   = bad;
    r.last_of_input = 1'b0;
    return r;
  endfunction

  // Appends one run at the tail of the expected queue.
  function automatic void queue_run(rled_pkg::result_t r);
    pending_runs = {pending_runs, r};
  endfunction

  // Works out the runs one byte produces and queues them behind earlier ones.
  function automatic void predict_runs(logic [rled_pkg::ByteW-1:0] b, logic eos);
    rled_pkg::cmd_type_t kind;
    int unsigned         produced;
    rled_pkg::result_t   tail;
    kind     = rled_pkg::cmd_type_t'(b[7:6]);
    produced = 0;

    // After an error every byte up to and including the stream end is dropped.
    if (dropping) begin
      if (eos) dropping = 1'b0;
      return;
    end

    if (hold_active) begin
      hold_active = 1'b0;
      // Held command followed by a pixel byte: that pixel repeats.
      if (kind == rled_pkg::CMD_PIXEL) begin
        tail = make_run(b, {1'b0, hold_code} + 7'd1, 1'b0);
        tail.last_of_input = 1'b1;
        queue_run(tail);
        return;
      end
      // Anything else: the held command is flushed as a single pixel first.
      queue_run(make_run({rled_pkg::PixelPrefix, hold_code}, 7'd1, 1'b0));
      produced++;
    end

    case (kind)
      rled_pkg::CMD_ZERO_RUN: begin
        queue_run(make_run('0, {1'b0, b[5:0]} + 7'd1, 1'b0));
        produced++;
      end
      rled_pkg::CMD_HOLD: begin
        // A hold command on the stream end cannot wait, so it flushes at once.
        if (eos) begin
          queue_run(make_run({rled_pkg::PixelPrefix, b[5:0]}, 7'd1, 1'b0));
          produced++;
        end else begin
          hold_active = 1'b1;
          hold_code   = b[5:0];
        end
      end
      default: begin
        queue_run(make_run(b, 7'd1, 1'b1));
        produced++;
        dropping = !eos;
      end
    endcase

    if (eos) hold_active = 1'b0;
    if (produced > 0) begin
      pending_runs[pending_runs.size() - 1].last_of_input = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking and watchdog: everything is sampled at the rising edge, before
  // any nonblocking update of that edge lands.
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("t=%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    rled_pkg::result_t want;
    if (!rst) begin
      // Output transfers are checked first; a byte's own runs cannot appear
      // on the edge that takes it, so the order here is free of races.
      if (out_valid && !out_stall) begin
        if (pending_runs.size() == 0) begin
          $display("t=%0t unexpected run: actual pixel %0h run %0d bad %0b last %0b",
                   $time, pixel, run_length, bad_command, last_of_input);
          fail_count++;
        end else begin
          want = pending_runs.pop_front();
          check_field("pixel", want.pixel, pixel);
          check_field("run_length", want.run_length, run_length);
          check_field("bad_command", want.bad_command, bad_command);
          check_field("last_of_input", want.last_of_input, last_of_input);
        end
      end
      if (in_valid && !in_stall) predict_runs(code_byte, stream_end);

      // Any transfer on either side counts as progress.
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("t=%0t watchdog: no transfer for %0d cycles", $time, QuietLimit);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offers one byte, after a random gap, and returns on the edge of its transfer.
  // in_valid is only lowered inside a gap, so back-to-back bytes keep it high.
  task automatic send_byte(input logic [rled_pkg::ByteW-1:0] b, input logic eos);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    code_byte  <= b;
    stream_end <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [rled_pkg::ByteW-1:0] cmd_byte(rled_pkg::cmd_type_t kind,
                                                          logic [rled_pkg::CodeW-1:0] code);
    return {kind, code};
  endfunction

  // Appends one legal element: a zero run, a hold with its pixel, or a lone
  // hold. In legal streams a lone hold meets 01, 10 or the stream end, so it flushes.
  function automatic void push_element(ref logic [rled_pkg::ByteW-1:0] seq[$]);
    case ($urandom_range(0, 2))
      0: seq = {seq, cmd_byte(rled_pkg::CMD_ZERO_RUN, rled_pkg::CodeW'($urandom))};
      1: begin
        seq = {seq, cmd_byte(rled_pkg::CMD_HOLD, rled_pkg::CodeW'($urandom))};
        seq = {seq, cmd_byte(rled_pkg::CMD_PIXEL, rled_pkg::CodeW'($urandom))};
      end
      default: seq = {seq, cmd_byte(rled_pkg::CMD_HOLD, rled_pkg::CodeW'($urandom))};
    endcase
  endfunction

  task automatic send_stream(input logic [rled_pkg::ByteW-1:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
  endtask

  task automatic set_idling(input int unsigned gap_pct, input int unsigned stall_pct);
    sender_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
  endtask

  // Field extremes, every command type and each corner of hold and discard.
  task automatic test_directed();
    send_byte(8'h40, 1'b0);  // shortest zero run
    send_byte(8'h7F, 1'b0);  // longest zero run
    send_byte(8'h80, 1'b0);  // hold, count 1 ...
    send_byte(8'hC0, 1'b0);  // ... repeated pixel
    send_byte(8'hBF, 1'b0);  // hold, count 64 ...
    send_byte(8'hFF, 1'b0);  // ... repeated pixel
    send_byte(8'h95, 1'b0);  // hold flushed ahead of a zero run: two runs
    send_byte(8'h4A, 1'b0);
    send_byte(8'hAA, 1'b0);  // hold flushed ahead of another hold
    send_byte(8'h81, 1'b0);
    send_byte(8'h3C, 1'b1);  // flush then error on the stream end: nothing dropped
    send_byte(8'hA5, 1'b1);  // hold on the stream end flushes at once
    send_byte(8'h83, 1'b0);  // held, then a hold on the stream end: two runs
    send_byte(8'h95, 1'b1);
    send_byte(8'h00, 1'b0);  // error of type 00, then bytes dropped to the end
    send_byte(8'h41, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h12, 1'b1);
    send_byte(8'h45, 1'b0);  // new stream decodes normally
    send_byte(8'hFF, 1'b0);  // error of type 11 in command position
    send_byte(8'h7F, 1'b1);
    send_byte(8'h9C, 1'b0);  // held, pixel arrives on the stream end
    send_byte(8'hE7, 1'b1);
    send_byte(8'h40, 1'b1);  // one-byte stream
  endtask

  // Legal streams of random content; mostly short, now and then long.
  task automatic test_wellformed_streams(input int unsigned n_bytes);
    logic [rled_pkg::ByteW-1:0] seq[$];
    int unsigned                sent;
    int unsigned                target;
    sent = 0;
    while (sent < n_bytes) begin
      seq.delete();
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
      while (seq.size() < target) push_element(seq);
      send_stream(seq);
      sent += seq.size();
    end
  endtask

  // A legal prefix, a bad command, then a tail that must be dropped.
  task automatic test_broken_streams(input int unsigned n_bytes);
    logic [rled_pkg::ByteW-1:0] seq[$];
    int unsigned                sent;
    int unsigned                k;
    sent = 0;
    while (sent < n_bytes) begin
      seq.delete();
      k = $urandom_range(0, 3);
      repeat (k) push_element(seq);
      seq = {seq, cmd_byte($urandom_range(0, 1) ? rled_pkg::CMD_PIXEL : rled_pkg::CMD_BAD_LOW,
                           rled_pkg::CodeW'($urandom))};
      k = $urandom_range(0, 4);
      repeat (k) seq = {seq, rled_pkg::ByteW'($urandom)};
      send_stream(seq);
      sent += seq.size();
    end
  endtask

  // Unstructured bytes with random stream ends.
  task automatic test_noise_bytes(input int unsigned n_bytes);
    repeat (n_bytes) send_byte(rled_pkg::ByteW'($urandom), $urandom_range(0, 5) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Sender idles often, receiver stalls more often still.
    set_idling(37, 78);
    test_directed();
    test_wellformed_streams(330);
    test_broken_streams(80);
    test_noise_bytes(40);

    // Rates swapped: output mostly free, input sparse.
    set_idling(78, 37);
    test_wellformed_streams(330);
    test_broken_streams(80);
    test_noise_bytes(40);

    // Full rate on both sides, so two-run bytes meet back-to-back traffic.
    set_idling(0, 0);
    test_wellformed_streams(330);
    test_broken_streams(80);
    test_noise_bytes(40);

    in_valid <= 1'b0;
    // Drain; the watchdog covers a run that never arrives.
    while (pending_runs.size() != 0) @(posedge clk);
    // Spare edges afterwards catch any stray extra transfer.
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> rle_pixel_run_decoder_top.f
hdl/rled_pkg.sv
hdl/rled_decode.sv
hdl/rle_pixel_run_decoder_top.sv
dv/tb_top.sv
